// ===== hdl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, register indexes and the per-opcode command program of the
// rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned PORT_W    = 64;
  localparam int unsigned WIDTH_DEF = 64;
  localparam int unsigned OP_W      = 4;
  localparam int unsigned PC_W      = 4;
  localparam int unsigned RIDX_W    = 3;
  localparam int unsigned NUM_REGS  = 8;

  // Request codes
  localparam logic [OP_W-1:0] OP_ADD     = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB     = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL     = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV     = 4'd3;
  localparam logic [OP_W-1:0] OP_ADD_INT = 4'd4;
  localparam logic [OP_W-1:0] OP_SUB_INT = 4'd5;
  localparam logic [OP_W-1:0] OP_MUL_INT = 4'd6;
  localparam logic [OP_W-1:0] OP_DIV_INT = 4'd7;
  localparam logic [OP_W-1:0] OP_CMP     = 4'd8;

  // Working register indexes
  localparam logic [RIDX_W-1:0] R_AN = 3'd0;
  localparam logic [RIDX_W-1:0] R_AD = 3'd1;
  localparam logic [RIDX_W-1:0] R_BN = 3'd2;
  localparam logic [RIDX_W-1:0] R_BD = 3'd3;
  localparam logic [RIDX_W-1:0] R_N  = 3'd4;
  localparam logic [RIDX_W-1:0] R_D  = 3'd5;
  localparam logic [RIDX_W-1:0] R_T  = 3'd6;
  localparam logic [RIDX_W-1:0] R_Z  = 3'd7;  // always zero

  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;
  localparam logic [1:0] ORD_LT = 2'b11;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_MUL,
    CMD_ADD,
    CMD_SUB,
    CMD_GCD,
    CMD_DIV,
    CMD_CMP,
    CMD_END
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [RIDX_W-1:0] dst;
    logic [RIDX_W-1:0] sx;
    logic [RIDX_W-1:0] sy;
  } step_t;

  typedef struct packed {
    logic  valid;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ISSUE,
    C_WAIT,
    C_RESULT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    G_IDLE,
    G_INIT,
    G_TWOS,
    G_XODD,
    G_LOOP
  } gcd_state_e;

  function automatic step_t mk(cmd_e kind, logic [RIDX_W-1:0] dst,
                               logic [RIDX_W-1:0] sx, logic [RIDX_W-1:0] sy);
    step_t s;
    s.kind = kind;
    s.dst  = dst;
    s.sx   = sx;
    s.sy   = sy;
    return s;
  endfunction

  // Reduce the result by its gcd: shared tail of several programs
  function automatic step_t reduce_tail(logic [PC_W-1:0] k);
    step_t s;
    unique case (k)
      4'd0:    s = mk(CMD_GCD, R_Z, R_N, R_D);
      4'd1:    s = mk(CMD_DIV, R_N, R_Z, R_Z);
      4'd2:    s = mk(CMD_DIV, R_D, R_Z, R_Z);
      default: s = mk(CMD_END, R_Z, R_Z, R_Z);
    endcase
    return s;
  endfunction

  function automatic step_t cross_prog(logic [PC_W-1:0] pc,
                                       logic [RIDX_W-1:0] bn,
                                       logic [RIDX_W-1:0] bd);
    step_t s;
    unique case (pc)
      4'd0:    s = mk(CMD_GCD, R_Z, R_AN, bd);
      4'd1:    s = mk(CMD_DIV, R_AN, R_Z, R_Z);
      4'd2:    s = mk(CMD_DIV, bd, R_Z, R_Z);
      4'd3:    s = mk(CMD_GCD, R_Z, bn, R_AD);
      4'd4:    s = mk(CMD_DIV, bn, R_Z, R_Z);
      4'd5:    s = mk(CMD_DIV, R_AD, R_Z, R_Z);
      4'd6:    s = mk(CMD_MUL, R_N, R_AN, bn);
      4'd7:    s = mk(CMD_MUL, R_D, R_AD, bd);
      default: s = mk(CMD_END, R_Z, R_Z, R_Z);
    endcase
    return s;
  endfunction

  function automatic step_t prog(logic [OP_W-1:0] op, logic [PC_W-1:0] pc);
    step_t s;
    s = mk(CMD_END, R_Z, R_Z, R_Z);
    unique case (op) inside
      OP_ADD, OP_SUB: begin
        unique case (pc)
          4'd0:    s = mk(CMD_MUL, R_N, R_AN, R_BD);
          4'd1:    s = mk(CMD_MUL, R_T, R_BN, R_AD);
          4'd2:    s = mk((op == OP_ADD) ? CMD_ADD : CMD_SUB, R_N, R_N, R_T);
          4'd3:    s = mk(CMD_MUL, R_D, R_AD, R_BD);
          default: s = reduce_tail(pc - 4'd4);
        endcase
      end
      OP_MUL: s = cross_prog(pc, R_BN, R_BD);
      OP_DIV: s = cross_prog(pc, R_BD, R_BN);
      OP_ADD_INT, OP_SUB_INT: begin
        unique case (pc)
          4'd0:    s = mk(CMD_MUL, R_T, R_BN, R_AD);
          4'd1:    s = mk((op == OP_ADD_INT) ? CMD_ADD : CMD_SUB, R_N, R_AN, R_T);
          4'd2:    s = mk(CMD_ADD, R_D, R_AD, R_Z);
          default: s = reduce_tail(pc - 4'd3);
        endcase
      end
      OP_MUL_INT: begin
        unique case (pc)
          4'd0:    s = mk(CMD_MUL, R_N, R_AN, R_BN);
          4'd1:    s = mk(CMD_ADD, R_D, R_AD, R_Z);
          default: s = reduce_tail(pc - 4'd2);
        endcase
      end
      OP_DIV_INT: begin
        unique case (pc)
          4'd0:    s = mk(CMD_ADD, R_N, R_AN, R_Z);
          4'd1:    s = mk(CMD_MUL, R_D, R_AD, R_BN);
          default: s = reduce_tail(pc - 4'd2);
        endcase
      end
      OP_CMP: begin
        unique case (pc)
          4'd0:    s = mk(CMD_MUL, R_T, R_AN, R_BD);
          4'd1:    s = mk(CMD_MUL, R_AD, R_BN, R_AD);
          4'd2:    s = mk(CMD_CMP, R_Z, R_T, R_AD);
          default: s = mk(CMD_END, R_Z, R_Z, R_Z);
        endcase
      end
      default: s = mk(CMD_END, R_Z, R_Z, R_Z);
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/rau_mul.sv =====
// ----------------------------------------------------------------------------
// rau_mul
// Shift-and-add multiplier, one multiplier bit per cycle, low product kept.
// ----------------------------------------------------------------------------
module rau_mul import rau_pkg::*; #(
  parameter int unsigned Width = WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  output logic             done_o,
  output logic [Width-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic             run_q, run_d, done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width-1:0] acc_q, acc_d, mc_q, mc_d, mp_q, mp_d;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CntW'(Width);
      acc_d = '0;
      mc_d  = a_i;
      mp_d  = b_i;
    end else if (run_q) begin
      if (mp_q[0]) begin
        acc_d = acc_q + mc_q;
      end
      mc_d  = {mc_q[Width-2:0], 1'b0};
      mp_d  = {1'b0, mp_q[Width-1:1]};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== hdl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div import rau_pkg::*; #(
  parameter int unsigned Width = WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic             run_q, run_d, done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [Width:0]   rs, diff;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rs     = {rem_q, quo_q[Width-1]};
    diff   = rs - {1'b0, dvs_q};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CntW'(Width);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d = diff[Width] ? rs[Width-1:0] : diff[Width-1:0];
      quo_d = {quo_q[Width-2:0], ~diff[Width]};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== hdl/rau_gcd.sv =====
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd of two unsigned magnitudes, one shift or subtract per cycle.
// ----------------------------------------------------------------------------
module rau_gcd import rau_pkg::*; #(
  parameter int unsigned Width = WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] x_i,
  input  logic [Width-1:0] y_i,
  output logic             done_o,
  output logic [Width-1:0] gcd_o
);

  localparam int unsigned ShW = $clog2(Width);

  gcd_state_e       state_q, state_d;
  logic             done_q, done_d;
  logic [ShW-1:0]   sh_q, sh_d;
  logic [Width-1:0] x_q, x_d, y_q, y_d, res_q, res_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      G_IDLE: if (start_i) state_d = G_INIT;
      G_INIT: begin
        if (x_q == '0 || y_q == '0) state_d = G_IDLE;
        else                        state_d = G_TWOS;
      end
      G_TWOS: if (x_q[0] | y_q[0]) state_d = G_XODD;
      G_XODD: if (x_q[0]) state_d = G_LOOP;
      G_LOOP: if (y_q == '0) state_d = G_IDLE;
      default: state_d = G_IDLE;
    endcase
  end

  always_comb begin
    done_d = 1'b0;
    sh_d   = sh_q;
    x_d    = x_q;
    y_d    = y_q;
    res_d  = res_q;
    unique case (state_q)
      G_IDLE: begin
        if (start_i) begin
          x_d  = x_i;
          y_d  = y_i;
          sh_d = '0;
        end
      end
      G_INIT: begin
        if (x_q == '0) begin
          res_d  = y_q;
          done_d = 1'b1;
        end else if (y_q == '0) begin
          res_d  = x_q;
          done_d = 1'b1;
        end
      end
      G_TWOS: begin
        if (!(x_q[0] | y_q[0])) begin
          x_d  = {1'b0, x_q[Width-1:1]};
          y_d  = {1'b0, y_q[Width-1:1]};
          sh_d = sh_q + ShW'(1);
        end
      end
      G_XODD: begin
        if (!x_q[0]) x_d = {1'b0, x_q[Width-1:1]};
      end
      G_LOOP: begin
        if (y_q == '0) begin
          res_d  = x_q << sh_q;
          done_d = 1'b1;
        end else if (!y_q[0]) begin
          y_d = {1'b0, y_q[Width-1:1]};
        end else if (x_q > y_q) begin
          // swap, then subtract
          x_d = y_q;
          y_d = x_q - y_q;
        end else begin
          y_d = y_q - x_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    x_q   <= x_d;
    y_q   <= y_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign gcd_o  = res_q;

endmodule

// ===== hdl/rau_dp.sv =====
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: working registers, gcd register and the shared multiply, gcd
// and divide units, driven one command at a time.
// ----------------------------------------------------------------------------
module rau_dp import rau_pkg::*; #(
  parameter int unsigned Width = WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [PORT_W-1:0] a_num_i,
  input  logic [PORT_W-1:0] a_den_i,
  input  logic [PORT_W-1:0] b_num_i,
  input  logic [PORT_W-1:0] b_den_i,
  output status_t           status_o,
  output logic [PORT_W-1:0] res_num_o,
  output logic [PORT_W-1:0] res_den_o,
  output logic [1:0]        order_o
);

  logic [Width-1:0]  rf_q [NUM_REGS];
  logic [Width-1:0]  rf_d [NUM_REGS];
  logic [Width-1:0]  g_q, g_d;
  logic [1:0]        ord_q, ord_d;
  logic [RIDX_W-1:0] dst_q, dst_d;
  logic              neg_q, neg_d;
  logic              sdone_q, sdone_d;

  logic [Width-1:0]  rx, ry, rdst, mag_x, mag_y, mag_dst;
  logic              mul_go, gcd_go, div_go;
  logic              mul_done, gcd_done, div_done;
  logic [Width-1:0]  mul_res, gcd_res, div_res;

  assign rx      = rf_q[cmd_i.step.sx];
  assign ry      = rf_q[cmd_i.step.sy];
  assign rdst    = rf_q[cmd_i.step.dst];
  assign mag_x   = rx[Width-1] ? (Width'(0) - rx) : rx;
  assign mag_y   = ry[Width-1] ? (Width'(0) - ry) : ry;
  assign mag_dst = rdst[Width-1] ? (Width'(0) - rdst) : rdst;

  always_comb begin
    rf_d    = rf_q;
    g_d     = g_q;
    ord_d   = ord_q;
    dst_d   = dst_q;
    neg_d   = neg_q;
    sdone_d = 1'b0;
    mul_go  = 1'b0;
    gcd_go  = 1'b0;
    div_go  = 1'b0;

    if (cmd_i.valid) begin
      dst_d = cmd_i.step.dst;
      unique case (cmd_i.step.kind)
        CMD_LOAD: begin
          for (int i = 0; i < NUM_REGS; i++) rf_d[i] = '0;
          rf_d[R_AN] = a_num_i[Width-1:0];
          rf_d[R_AD] = a_den_i[Width-1:0];
          rf_d[R_BN] = b_num_i[Width-1:0];
          rf_d[R_BD] = b_den_i[Width-1:0];
          ord_d      = ORD_EQ;
        end
        CMD_MUL: mul_go = 1'b1;
        CMD_ADD: begin
          rf_d[cmd_i.step.dst] = rx + ry;
          sdone_d = 1'b1;
        end
        CMD_SUB: begin
          rf_d[cmd_i.step.dst] = rx - ry;
          sdone_d = 1'b1;
        end
        CMD_GCD: gcd_go = 1'b1;
        CMD_DIV: begin
          // a zero gcd leaves the value as is
          if (g_q == '0) begin
            sdone_d = 1'b1;
          end else begin
            div_go = 1'b1;
            neg_d  = rdst[Width-1];
          end
        end
        CMD_CMP: begin
          if ($signed(rx) > $signed(ry))      ord_d = ORD_GT;
          else if ($signed(rx) < $signed(ry)) ord_d = ORD_LT;
          else                                ord_d = ORD_EQ;
          sdone_d = 1'b1;
        end
        default: ;
      endcase
    end

    if (mul_done) rf_d[dst_q] = mul_res;
    if (div_done) rf_d[dst_q] = neg_q ? (Width'(0) - div_res) : div_res;
    if (gcd_done) g_d = gcd_res;
  end

  rau_mul #(.Width(Width)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_go),
    .a_i    (rx),
    .b_i    (ry),
    .done_o (mul_done),
    .prod_o (mul_res)
  );

  rau_gcd #(.Width(Width)) u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(gcd_go),
    .x_i    (mag_x),
    .y_i    (mag_y),
    .done_o (gcd_done),
    .gcd_o  (gcd_res)
  );

  rau_div #(.Width(Width)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_go),
    .dividend_i(mag_dst),
    .divisor_i (g_q),
    .done_o    (div_done),
    .quot_o    (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdone_q <= 1'b0;
    end else begin
      sdone_q <= sdone_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rf_q  <= rf_d;
    g_q   <= g_d;
    ord_q <= ord_d;
    dst_q <= dst_d;
    neg_q <= neg_d;
  end

  assign status_o.done = sdone_q | mul_done | gcd_done | div_done;
  assign res_num_o = PORT_W'($signed(rf_q[R_N]));
  assign res_den_o = PORT_W'($signed(rf_q[R_D]));
  assign order_o   = ord_q;

endmodule

// ===== hdl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// Controller: accepts a request, steps through its command program and
// strobes the result.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [OP_W-1:0] req_type_i,
  input  status_t         status_i,
  output cmd_t            cmd_o,
  output logic            busy_o,
  output logic            res_valid_o
);

  ctrl_state_e     state_q, state_d;
  logic [OP_W-1:0] op_q, op_d;
  logic [PC_W-1:0] pc_q, pc_d;
  step_t           cur;

  assign cur = prog(op_q, pc_q);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    pc_d    = pc_q;
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          state_d = C_ISSUE;
          op_d    = req_type_i;
          pc_d    = '0;
        end
      end
      C_ISSUE: state_d = (cur.kind == CMD_END) ? C_RESULT : C_WAIT;
      C_WAIT: begin
        if (status_i.done) begin
          state_d = C_ISSUE;
          pc_d    = pc_q + PC_W'(1);
        end
      end
      C_RESULT: state_d = C_IDLE;
      default:  state_d = C_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.valid = 1'b0;
    cmd_o.step  = mk(CMD_NOP, R_Z, R_Z, R_Z);
    unique case (state_q)
      C_IDLE: begin
        // capture operands on the accepting edge
        cmd_o.valid = start_i;
        cmd_o.step  = mk(CMD_LOAD, R_Z, R_Z, R_Z);
      end
      C_ISSUE: begin
        cmd_o.valid = (cur.kind != CMD_END);
        cmd_o.step  = cur;
      end
      default: ;
    endcase
  end

  assign busy_o      = (state_q != C_IDLE);
  assign res_valid_o = (state_q == C_RESULT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      op_q    <= '0;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      pc_q    <= pc_d;
    end
  end

endmodule

// ===== hdl/rational_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Add, subtract, multiply, divide and compare of rationals, gcd-reduced.
// ----------------------------------------------------------------------------
// Usage: drive req_type_i and the four operands, raise start. The beat is
// taken at a rising edge with start high and busy low; operands are captured
// then and need not be held. busy stays high until the result is out.
// The result appears on res_num_o, res_den_o and order_o for exactly one
// cycle with res_valid_o high; the receiver must take it then, there is no
// backpressure. Values are WIDTH bits, sign-extended to the 64-bit ports.
// Run time is set by the shared iterative units, which serve one program
// step at a time. Add and subtract run three multiplies, one gcd and two
// divides. Unused codes return zeros. One request is in flight at a time.
// Reset clears the controller; the block is idle and ready right after it.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top import rau_pkg::*; #(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   req_type_i,
  input  logic [PORT_W-1:0] a_num_i,
  input  logic [PORT_W-1:0] a_den_i,
  input  logic [PORT_W-1:0] b_num_i,
  input  logic [PORT_W-1:0] b_den_i,
  output logic              res_valid_o,
  output logic [PORT_W-1:0] res_num_o,
  output logic [PORT_W-1:0] res_den_o,
  output logic [1:0]        order_o
);

  cmd_t    cmd;
  status_t status;

  rau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .res_valid_o(res_valid_o)
  );

  rau_dp #(.Width(WIDTH)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .a_num_i  (a_num_i),
    .a_den_i  (a_den_i),
    .b_num_i  (b_num_i),
    .b_den_i  (b_den_i),
    .status_o (status),
    .res_num_o(res_num_o),
    .res_den_o(res_den_o),
    .order_o  (order_o)
  );

endmodule

// ===== bench/rational_arithmetic_unit_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top_tb
// Drives a table of directed rational requests and then random requests with
// bursty start timing; every result is compared field by field against a
// fixed table answer or an in-bench predictor of gcd-reduced rationals.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top_tb;
  import rau_pkg::*;

  localparam int unsigned N_RANDOM = 1500;

  typedef logic [63:0] word_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    word_t           an;
    word_t           ad;
    word_t           bn;
    word_t           bd;
  } request_t;

  typedef struct packed {
    word_t      num;
    word_t      den;
    logic [1:0] ord;
  } answer_t;

  typedef struct {
    request_t req;
    logic     fixed;
    answer_t  ans;
  } row_t;

  localparam word_t MAXP = 64'h7fff_ffff_ffff_ffff;
  localparam word_t MINN = 64'h8000_0000_0000_0000;
  localparam word_t ONES = 64'hffff_ffff_ffff_ffff;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   req_type_i;
  word_t             a_num_i, a_den_i, b_num_i, b_den_i;
  logic              res_valid_o;
  word_t             res_num_o, res_den_o;
  logic [1:0]        order_o;

  answer_t pending_answers[$];
  int      mismatch_count;
  bit      run_failed;

  bit      directed_active;
  bit      directed_fixed;
  answer_t directed_answer;

  rational_arithmetic_unit_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_type_i(req_type_i), .a_num_i(a_num_i), .a_den_i(a_den_i),
    .b_num_i(b_num_i), .b_den_i(b_den_i), .res_valid_o(res_valid_o),
    .res_num_o(res_num_o), .res_den_o(res_den_o), .order_o(order_o)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic word_t mag(word_t v);
    return v[63] ? -v : v;
  endfunction

  function automatic word_t gcd_of(word_t x, word_t y);
    word_t a, b, t;
    a = mag(x);
    b = mag(y);
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic word_t exact_div(word_t v, word_t g);
    word_t q;
    q = mag(v) / g;
    return v[63] ? -q : q;
  endfunction

  function automatic void reduce_pair(inout word_t n, inout word_t d);
    word_t g;
    g = gcd_of(n, d);
    if (g != 0) begin
      n = exact_div(n, g);
      d = exact_div(d, g);
    end
  endfunction

  function automatic void cross_product(word_t an, word_t ad, word_t bn, word_t bd,
                                        output word_t n, output word_t d);
    reduce_pair(an, bd);
    reduce_pair(bn, ad);
    n = an * bn;
    d = ad * bd;
  endfunction

  function automatic answer_t rational_result(request_t r);
    answer_t a;
    word_t   l, rr;
    a = '0;
    case (r.op) inside
      OP_ADD, OP_SUB: begin
        a.num = (r.op == OP_ADD) ? r.an * r.bd + r.bn * r.ad : r.an * r.bd - r.bn * r.ad;
        a.den = r.ad * r.bd;
        reduce_pair(a.num, a.den);
      end
      OP_MUL: cross_product(r.an, r.ad, r.bn, r.bd, a.num, a.den);
      OP_DIV: cross_product(r.an, r.ad, r.bd, r.bn, a.num, a.den);
      OP_ADD_INT, OP_SUB_INT: begin
        a.num = (r.op == OP_ADD_INT) ? r.an + r.bn * r.ad : r.an - r.bn * r.ad;
        a.den = r.ad;
        reduce_pair(a.num, a.den);
      end
      OP_MUL_INT: begin
        a.num = r.an * r.bn;
        a.den = r.ad;
        reduce_pair(a.num, a.den);
      end
      OP_DIV_INT: begin
        a.num = r.an;
        a.den = r.ad * r.bn;
        reduce_pair(a.num, a.den);
      end
      OP_CMP: begin
        l  = $signed(r.an * r.bd);
        rr = $signed(r.bn * r.ad);
        if ($signed(l) > $signed(rr))      a.ord = ORD_GT;
        else if ($signed(l) < $signed(rr)) a.ord = ORD_LT;
        else                               a.ord = ORD_EQ;
      end
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic word_t rand_word();
    word_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = $urandom_range(20);
      1: v = -word_t'($urandom_range(20));
      2: v = $signed(v) >>> $urandom_range(63);
      3: v = {$urandom_range(3) == 0 ? MINN[63:62] : v[63:62], v[61:0]};
      4: v = word_t'($urandom_range(1000)) << $urandom_range(40);
      5: v = ($urandom_range(1) ? MAXP : MINN) ^ word_t'($urandom_range(3));
      default: ;
    endcase
    return v;
  endfunction

  // Send one beat: hold start until busy is low at an edge
  task automatic send(request_t r);
    start      <= 1'b1;
    req_type_i <= r.op;
    a_num_i    <= r.an;
    a_den_i    <= r.ad;
    b_num_i    <= r.bn;
    b_den_i    <= r.bd;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_answers.size() == 0) begin
        run_failed = 1'b1;
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %h/%h ord %b",
                                           res_num_o, res_den_o, order_o);
      end else begin
        answer_t e;
        e = pending_answers.pop_front();
        if (e.num !== res_num_o || e.den !== res_den_o || e.ord !== order_o) begin
          run_failed = 1'b1;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %h/%h ord %b, got %h/%h ord %b",
                     e.num, e.den, e.ord, res_num_o, res_den_o, order_o);
        end
      end
    end
  end

  // Record the expectation on acceptance of each beat
  request_t accepted_req;
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      accepted_req = '{req_type_i, a_num_i, a_den_i, b_num_i, b_den_i};
      if (directed_active && directed_fixed)
        pending_answers.push_back(directed_answer);
      else
        pending_answers.push_back(rational_result(accepted_req));
    end
  end

  row_t directed_rows[] = '{
    '{'{OP_ADD, 64'd1, 64'd2, 64'd1, 64'd3}, 1'b1, '{64'd5, 64'd6, ORD_EQ}},
    '{'{OP_SUB, 64'd1, 64'd2, 64'd1, 64'd3}, 1'b1, '{64'd1, 64'd6, ORD_EQ}},
    '{'{OP_MUL, 64'd2, 64'd3, 64'd3, 64'd4}, 1'b1, '{64'd1, 64'd2, ORD_EQ}},
    '{'{OP_DIV, 64'd2, 64'd3, 64'd4, 64'd3}, 1'b1, '{64'd1, 64'd2, ORD_EQ}},
    '{'{OP_ADD_INT, 64'd1, 64'd2, 64'd3, 64'd0}, 1'b1, '{64'd7, 64'd2, ORD_EQ}},
    '{'{OP_SUB_INT, 64'd1, 64'd2, 64'd1, 64'd9}, 1'b1, '{ONES, 64'd2, ORD_EQ}},
    '{'{OP_MUL_INT, 64'd1, 64'd4, 64'd2, 64'd0}, 1'b1, '{64'd1, 64'd2, ORD_EQ}},
    '{'{OP_DIV_INT, 64'd2, 64'd3, 64'd4, ONES}, 1'b1, '{64'd1, 64'd6, ORD_EQ}},
    '{'{OP_CMP, 64'd1, 64'd2, 64'd1, 64'd3}, 1'b1, '{64'd0, 64'd0, ORD_GT}},
    '{'{OP_CMP, 64'd1, 64'd3, 64'd1, 64'd2}, 1'b1, '{64'd0, 64'd0, ORD_LT}},
    '{'{OP_CMP, 64'd2, 64'd4, 64'd1, 64'd2}, 1'b1, '{64'd0, 64'd0, ORD_EQ}},
    '{'{OP_ADD, 64'd0, 64'd0, 64'd0, 64'd0}, 1'b1, '{64'd0, 64'd0, ORD_EQ}},
    '{'{OP_MUL, 64'd0, 64'd0, 64'd0, 64'd0}, 1'b1, '{64'd0, 64'd0, ORD_EQ}},
    '{'{OP_ADD, 64'd3, 64'd0, 64'd5, 64'd7}, 1'b0, '0},
    '{'{OP_DIV_INT, 64'd5, 64'd3, 64'd0, 64'd0}, 1'b0, '0},
    '{'{4'd9, MAXP, MINN, ONES, 64'd1}, 1'b1, '{64'd0, 64'd0, ORD_EQ}},
    '{'{4'd15, ONES, ONES, ONES, ONES}, 1'b1, '{64'd0, 64'd0, ORD_EQ}},
    '{'{OP_MUL_INT, MINN, 64'd1, 64'd1, 64'd0}, 1'b0, '0},
    '{'{OP_SUB, MINN, ONES, MAXP, 64'd1}, 1'b0, '0},
    '{'{OP_DIV, MINN, MINN, MINN, MINN}, 1'b0, '0},
    '{'{OP_CMP, MAXP, 64'd1, MINN, 64'd1}, 1'b0, '0},
    '{'{OP_ADD_INT, MAXP, MAXP, MAXP, MAXP}, 1'b0, '0},
    '{'{OP_MUL, MINN, 64'd3, 64'd6, ONES}, 1'b0, '0},
    '{'{OP_DIV_INT, ONES, MINN, ONES, 64'd0}, 1'b0, '0}
  };

  initial begin
    request_t r;
    int       burst;
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_type_i      = '0;
    a_num_i         = '0;
    a_den_i         = '0;
    b_num_i         = '0;
    b_den_i         = '0;
    mismatch_count  = 0;
    run_failed      = 1'b0;
    directed_active = 1'b1;
    directed_fixed  = 1'b0;
    directed_answer = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      directed_fixed  <= directed_rows[i].fixed;
      directed_answer <= directed_rows[i].ans;
      send(directed_rows[i].req);
      idle_cycles($urandom_range(1) ? 0 : $urandom_range(1, 6));
    end
    directed_active <= 1'b0;

    burst = 0;
    for (int k = 0; k < N_RANDOM; k++) begin
      r.op = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
      r.an = rand_word();
      r.ad = rand_word();
      r.bn = rand_word();
      r.bd = rand_word();
      // operands with a shared factor make reduction do real work
      if ($urandom_range(2) == 0) begin
        r.ad = r.ad & 64'hffff;
        r.bd = r.ad * $urandom_range(1, 50);
      end
      send(r);
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        idle_cycles($urandom_range(3) == 0 ? 0 : $urandom_range(1, 300));
      end else begin
        burst--;
      end
    end
    start <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (!run_failed) begin
      $display("rational_arithmetic_unit_top verification clean");
    end else begin
      $display("rational_arithmetic_unit_top verification failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("rational_arithmetic_unit_top verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rau_pkg.sv
hdl/rau_mul.sv
hdl/rau_div.sv
hdl/rau_gcd.sv
hdl/rau_dp.sv
hdl/rau_ctrl.sv
hdl/rational_arithmetic_unit_top.sv
bench/rational_arithmetic_unit_top_tb.sv
